@@ rtl/hbt_pkg.sv @@
package hbt_pkg;

	// Frame fields
	localparam logic [3:0] HB_FUNC_CODE = 4'hE;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID  = 1'b1;

	// Configuration reset values
	localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
	localparam logic [6:0]  OWN_ID_RESET  = 7'd1;

	// Input operation codes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [10:0] cob_id;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic       changed;
		logic [7:0] connected_count;
	} out_item_t;

	// Classified command passed from front to back
	typedef enum logic [1:0] {
		CMD_NOP  = 2'd0,
		CMD_HB   = 2'd1,
		CMD_TICK = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [6:0]  node;
		logic [31:0] value;   // deadline for a heartbeat, current time for a tick
	} cmd_t;

endpackage

@@ rtl/hbt_ram.sv @@
module hbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/hbt_front.sv @@
module hbt_front #(
	parameter int NODE_SLOTS = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  hbt_pkg::in_item_t                in_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                      cfg_data,
	output logic                             cmd_valid,
	input  logic                             cmd_ready,
	output hbt_pkg::cmd_t                    cmd
);

	logic [15:0] timeout_q;
	logic [6:0]  own_id_q;
	logic [3:0]  func;
	logic [6:0]  node;
	logic        is_hb;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= hbt_pkg::TIMEOUT_RESET;
			own_id_q  <= hbt_pkg::OWN_ID_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hbt_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				hbt_pkg::REG_OWN_ID:  own_id_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Classify the incoming transaction
	assign func  = in_data.cob_id[10:7];
	assign node  = in_data.cob_id[6:0];
	assign is_hb = (func == hbt_pkg::HB_FUNC_CODE) && (node != own_id_q)
		&& ({1'b0, node} < 8'(NODE_SLOTS));

	always_comb begin
		cmd.node = node;
		if (in_data.operation == hbt_pkg::OP_TICK) begin
			cmd.kind  = hbt_pkg::CMD_TICK;
			cmd.value = in_data.now_ms;
		end else begin
			cmd.kind  = is_hb ? hbt_pkg::CMD_HB : hbt_pkg::CMD_NOP;
			// deadline wraps modulo 2^32
			cmd.value = in_data.now_ms + {16'd0, timeout_q};
		end
	end

	// Hand off to the queue
	assign cmd_valid = in_valid;
	assign in_ready  = cmd_ready;

endmodule

@@ rtl/hbt_queue.sv @@
module hbt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  hbt_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output hbt_pkg::cmd_t pop_cmd
);

	hbt_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    level_q;
	logic          push;
	logic          pop;

	assign push_ready = (level_q != 2'd2);
	assign pop_valid  = (level_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

@@ rtl/hbt_back.sv @@
module hbt_back #(
	parameter int NODE_SLOTS = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  hbt_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output hbt_pkg::out_item_t out_data
);

	localparam int IDXW = $clog2(NODE_SLOTS);
	localparam int CNTW = $clog2(NODE_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

	state_t             state_q;
	logic [NODE_SLOTS-1:0] present_q;
	logic [CNTW-1:0]    count_q;
	logic [IDXW:0]      rd_idx_q;
	logic               chk_vld_s1;
	logic [IDXW-1:0]    chk_idx_s1;
	logic [31:0]        now_q;
	logic               changed_q;
	logic               out_valid_q;
	hbt_pkg::out_item_t out_q;

	logic               pop;
	logic [IDXW-1:0]    hb_node;
	logic               ram_we;
	logic               issue;
	logic [31:0]        rdata;
	logic               expire;
	logic               last;
	logic [CNTW-1:0]    count_dec;

	assign pop       = (state_q == ST_IDLE) && cmd_valid && !out_valid_q;
	assign cmd_ready = pop;
	assign hb_node   = cmd.node[IDXW-1:0];
	assign ram_we    = pop && (cmd.kind == hbt_pkg::CMD_HB);

	// Sweep read and compare
	assign issue     = (state_q == ST_SWEEP) && (rd_idx_q < (IDXW+1)'(NODE_SLOTS));
	assign expire    = chk_vld_s1 && present_q[chk_idx_s1] && (now_q > rdata);
	assign last      = chk_vld_s1 && (chk_idx_s1 == IDXW'(NODE_SLOTS - 1));
	assign count_dec = count_q - CNTW'(expire);

	hbt_ram #(
		.WIDTH (32),
		.DEPTH (NODE_SLOTS)
	) u_deadline (
		.clk   (clk),
		.we    (ram_we),
		.waddr (hb_node),
		.wdata (cmd.value),
		.re    (issue),
		.raddr (rd_idx_q[IDXW-1:0]),
		.rdata (rdata)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Execute commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			present_q   <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			chk_vld_s1  <= 1'b0;
			chk_idx_s1  <= '0;
			now_q       <= '0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// drop the result once taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (cmd.kind)
							hbt_pkg::CMD_HB: begin
								out_valid_q <= 1'b1;
								if (!present_q[hb_node]) begin
									present_q[hb_node]    <= 1'b1;
									count_q               <= count_q + CNTW'(1);
									out_q.changed         <= 1'b1;
									out_q.connected_count <= 8'(count_q + CNTW'(1));
								end else begin
									out_q.changed         <= 1'b0;
									out_q.connected_count <= 8'(count_q);
								end
							end
							hbt_pkg::CMD_TICK: begin
								now_q     <= cmd.value;
								rd_idx_q  <= '0;
								changed_q <= 1'b0;
								state_q   <= ST_SWEEP;
							end
							default: begin
								out_valid_q           <= 1'b1;
								out_q.changed         <= 1'b0;
								out_q.connected_count <= 8'(count_q);
							end
						endcase
					end
				end
				ST_SWEEP: begin
					chk_vld_s1 <= issue;
					chk_idx_s1 <= rd_idx_q[IDXW-1:0];
					if (issue) begin
						rd_idx_q <= rd_idx_q + (IDXW+1)'(1);
					end
					// drop a late node
					if (expire) begin
						present_q[chk_idx_s1] <= 1'b0;
						count_q               <= count_dec;
						changed_q             <= 1'b1;
					end
					if (last) begin
						out_valid_q           <= 1'b1;
						out_q.changed         <= changed_q | expire;
						out_q.connected_count <= 8'(count_dec);
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Count tracks the presence bits
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNTW'($countones(present_q)))
		else $error("present count out of step with presence bits");

	// No result appears while a sweep is still running
	a_no_out_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !out_valid_q)
		else $error("result pending during sweep");

	// A command is taken only when the output register is free, and it yields a result or a sweep
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> out_valid_q || (state_q == ST_SWEEP))
		else $error("command taken without producing a result or sweep");

	// Compare stage runs only inside a sweep
	a_chk_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (state_q == ST_SWEEP))
		else $error("compare stage active outside sweep");

endmodule

@@ rtl/heartbeat_node_liveness_table.sv @@
// Heartbeat frame: the front end classifies it, the queue registers it, and the back end
// registers its result when it is free. Tick: the sweep reads one deadline per cycle
// from the deadline RAM and registers the result once the last node is compared.
// The back end takes no new command during a sweep or while a result waits to be taken.
// Reset clears all presence bits, the count and the queue at once; registers
// return to timeout 3000 ms and own node 1. Deadline RAM contents stay undefined.
module heartbeat_node_liveness_table #(
	parameter int NODE_SLOTS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  hbt_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output hbt_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	logic          fq_valid;
	logic          fq_ready;
	hbt_pkg::cmd_t fq_cmd;
	logic          qb_valid;
	logic          qb_ready;
	hbt_pkg::cmd_t qb_cmd;

	hbt_front #(
		.NODE_SLOTS (NODE_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	hbt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	hbt_back #(
		.NODE_SLOTS (NODE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ verif/heartbeat_node_liveness_table_test.sv @@
module heartbeat_node_liveness_table_test;

	localparam int NODE_SLOTS = 128;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	hbt_pkg::in_item_t             in_data;
	logic                          out_valid;
	logic                          out_ready;
	hbt_pkg::out_item_t            out_data;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [hbt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                   cfg_data;

	// Shadow copy of the liveness table and its registers
	logic [15:0] timeout_shadow;
	logic [6:0]  own_id_shadow;
	logic        node_alive [NODE_SLOTS];
	logic [31:0] node_due [NODE_SLOTS];
	logic [7:0]  alive_count;

	hbt_pkg::out_item_t liveness_expected[$];

	// Run control and statistics
	logic [31:0] clock_ms;
	bit          gaps_enabled;
	int unsigned sink_hold_cycles;
	int unsigned error_count;
	int unsigned frames_sent;
	int unsigned ticks_sent;
	int unsigned nodes_joined;
	int unsigned nodes_expired;
	int unsigned results_checked;

	heartbeat_node_liveness_table #(
		.NODE_SLOTS(NODE_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Hard limit on the run
	initial begin
		#20_000_000;
		$display("%0t: timeout, %0d results still outstanding", $time,
			liveness_expected.size());
		$display("heartbeat_node_liveness_table_test failed");
		$finish;
	end

	// Idle length: mostly none or short, now and then long enough to span a sweep
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 16);
		else
			return $urandom_range(40, 160);
	endfunction

	// Apply one transaction to the shadow table and return the status it yields
	function automatic hbt_pkg::out_item_t predict_liveness(input hbt_pkg::in_item_t item);
		hbt_pkg::out_item_t status;
		logic [6:0]         node;
		status.changed = 1'b0;
		node = item.cob_id[6:0];
		if (item.operation == hbt_pkg::OP_FRAME) begin
			if (item.cob_id[10:7] == hbt_pkg::HB_FUNC_CODE && node != own_id_shadow) begin
				node_due[node] = item.now_ms + {16'd0, timeout_shadow};
				if (!node_alive[node]) begin
					node_alive[node] = 1'b1;
					alive_count = alive_count + 8'd1;
					status.changed = 1'b1;
					nodes_joined++;
				end
			end
		end else begin
			for (int i = 0; i < NODE_SLOTS; i++) begin
				if (node_alive[i] && item.now_ms > node_due[i]) begin
					node_alive[i] = 1'b0;
					alive_count = alive_count - 8'd1;
					status.changed = 1'b1;
					nodes_expired++;
				end
			end
		end
		status.connected_count = alive_count;
		return status;
	endfunction

	function automatic hbt_pkg::in_item_t make_item(input logic op, input logic [10:0] cob,
			input logic [31:0] now);
		hbt_pkg::in_item_t item;
		item.operation = op;
		item.cob_id = cob;
		item.now_ms = now;
		return item;
	endfunction

	// Offer one item after a random gap, hold it until accepted, then predict
	task automatic send_item(input hbt_pkg::in_item_t item);
		int unsigned gap;
		gap = gaps_enabled ? idle_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		liveness_expected.insert(liveness_expected.size(), predict_liveness(item));
		if (item.operation == hbt_pkg::OP_FRAME)
			frames_sent++;
		else
			ticks_sent++;
	endtask

	// Drop valid and let every outstanding result drain
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (liveness_expected.size() != 0) @(posedge clk);
		repeat (NODE_SLOTS + 8) @(posedge clk);
	endtask

	task automatic write_register(input logic [hbt_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			hbt_pkg::REG_TIMEOUT: timeout_shadow = value;
			hbt_pkg::REG_OWN_ID: own_id_shadow = value[6:0];
		endcase
		@(posedge clk);
	endtask

	// Mostly heartbeats, half on a small node pool, some foreign frames, ticks, odd times
	task automatic make_random_item(input int unsigned step_max,
			output hbt_pkg::in_item_t item);
		int unsigned pick;
		logic [6:0]  node;
		pick = $urandom_range(0, 99);
		clock_ms = clock_ms + $urandom_range(0, step_max);
		if ($urandom_range(0, 99) < 4)
			node = own_id_shadow;
		else if ($urandom_range(0, 1))
			node = 7'($urandom_range(0, 11));
		else
			node = 7'($urandom);
		item.operation = hbt_pkg::OP_FRAME;
		item.cob_id = {hbt_pkg::HB_FUNC_CODE, node};
		item.now_ms = clock_ms;
		if (pick >= 60 && pick < 70) begin
			item.cob_id = 11'($urandom);
		end else if (pick >= 70) begin
			item.operation = hbt_pkg::OP_TICK;
			item.cob_id = 11'($urandom);
		end
		if ($urandom_range(0, 99) < 3)
			item.now_ms = $urandom;
	endtask

	task automatic run_random_traffic(input int unsigned count, input int unsigned step_max);
		hbt_pkg::in_item_t item;
		for (int unsigned k = 0; k < count; k++) begin
			make_random_item(step_max, item);
			send_item(item);
		end
	endtask

	// Reset values: own node 1, timeout 3000
	task automatic test_reset_defaults();
		send_item(make_item(hbt_pkg::OP_TICK, 11'h000, 32'd0));
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd0}, 32'd100));
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd1}, 32'd100));
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd127}, 32'd100));
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd0}, 32'd2000));
		send_item(make_item(hbt_pkg::OP_FRAME, {4'h7, 7'd5}, 32'd2100));
		send_item(make_item(hbt_pkg::OP_FRAME, 11'h7FF, 32'd2100));
		send_item(make_item(hbt_pkg::OP_FRAME, 11'h000, 32'd2100));
		// deadline equal to now keeps the node, one past drops it
		send_item(make_item(hbt_pkg::OP_TICK, 11'h7FF, 32'd3100));
		send_item(make_item(hbt_pkg::OP_TICK, 11'h000, 32'd3101));
		send_item(make_item(hbt_pkg::OP_TICK, 11'h000, 32'd5001));
		// deadline wraps past the top of the time range
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd5},
			32'hFFFF_FFFF));
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd6}, 32'd10));
		send_item(make_item(hbt_pkg::OP_TICK, 11'h555, 32'hFFFF_FFF0));
		send_item(make_item(hbt_pkg::OP_TICK, 11'h2AA, 32'hFFFF_FFFF));
		wait_drained();
	endtask

	// Zero and full-scale timeout, own node at both ends, masked upper data bits
	task automatic test_register_extremes();
		write_register(hbt_pkg::REG_TIMEOUT, 16'd0);
		write_register(hbt_pkg::REG_OWN_ID, 16'hFF80);
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd0}, 32'd500));
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd1}, 32'd500));
		send_item(make_item(hbt_pkg::OP_TICK, 11'h000, 32'd500));
		send_item(make_item(hbt_pkg::OP_TICK, 11'h000, 32'd501));
		wait_drained();
		write_register(hbt_pkg::REG_TIMEOUT, 16'hFFFF);
		write_register(hbt_pkg::REG_OWN_ID, 16'h557F);
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd127}, 32'd0));
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd126},
			32'hFFFF_0000));
		send_item(make_item(hbt_pkg::OP_FRAME, {hbt_pkg::HB_FUNC_CODE, 7'd1},
			32'hFFFF_0001));
		send_item(make_item(hbt_pkg::OP_TICK, 11'h000, 32'hFFFF_FFFF));
		send_item(make_item(hbt_pkg::OP_TICK, 11'h000, 32'd0));
		wait_drained();
	endtask

	// Random phases across several register settings
	task automatic test_random_traffic();
		int unsigned tmo;
		write_register(hbt_pkg::REG_TIMEOUT, 16'd40);
		write_register(hbt_pkg::REG_OWN_ID, 16'($urandom));
		clock_ms = 32'd1000;
		gaps_enabled = 1'b1;
		run_random_traffic(220, 12);
		wait_drained();

		// one-millisecond timeout, no idling on either side
		write_register(hbt_pkg::REG_TIMEOUT, 16'd1);
		write_register(hbt_pkg::REG_OWN_ID, 16'd0);
		gaps_enabled = 1'b0;
		run_random_traffic(150, 2);
		wait_drained();

		// full-scale timeout with the clock wrapping
		write_register(hbt_pkg::REG_TIMEOUT, 16'hFFFF);
		write_register(hbt_pkg::REG_OWN_ID, 16'd127);
		clock_ms = 32'hFFFF_0000;
		gaps_enabled = 1'b1;
		run_random_traffic(180, 3000);
		wait_drained();

		tmo = $urandom_range(100, 5000);
		write_register(hbt_pkg::REG_TIMEOUT, 16'(tmo));
		write_register(hbt_pkg::REG_OWN_ID, 16'($urandom));
		clock_ms = $urandom;
		run_random_traffic(200, tmo / 3);
		wait_drained();
	endtask

	// Receiver holds off while items keep coming, then the sender waits for drain
	task automatic test_output_backpressure();
		write_register(hbt_pkg::REG_TIMEOUT, 16'd500);
		clock_ms = 32'd0;
		gaps_enabled = 1'b0;
		sink_hold_cycles = 600;
		run_random_traffic(120, 50);
		gaps_enabled = 1'b1;
		wait_drained();
		run_random_traffic(60, 50);
		wait_drained();
	endtask

	// Result receiver: random stalls, long hold when requested
	initial begin
		int unsigned span;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_cycles > 0) begin
				span = sink_hold_cycles;
				sink_hold_cycles = 0;
				out_ready <= 1'b0;
				repeat (span) @(posedge clk);
			end else if (!gaps_enabled || $urandom_range(0, 99) < 60) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (idle_gap() + 1) @(posedge clk);
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		hbt_pkg::out_item_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (liveness_expected.size() == 0) begin
				$display("%0t: unexpected result changed=%0b count=%0d", $time,
					out_data.changed, out_data.connected_count);
				error_count++;
			end else begin
				want = liveness_expected.pop_front();
				results_checked++;
				if (out_data.changed !== want.changed) begin
					$display("%0t: changed mismatch, expected %0b actual %0b", $time,
						want.changed, out_data.changed);
					error_count++;
				end
				if (out_data.connected_count !== want.connected_count) begin
					$display("%0t: connected_count mismatch, expected %0d actual %0d",
						$time, want.connected_count, out_data.connected_count);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = hbt_pkg::REG_TIMEOUT;
		cfg_data = '0;
		gaps_enabled = 1'b1;
		sink_hold_cycles = 0;
		clock_ms = '0;
		error_count = 0;
		frames_sent = 0;
		ticks_sent = 0;
		nodes_joined = 0;
		nodes_expired = 0;
		results_checked = 0;
		timeout_shadow = hbt_pkg::TIMEOUT_RESET;
		own_id_shadow = hbt_pkg::OWN_ID_RESET;
		alive_count = '0;
		for (int i = 0; i < NODE_SLOTS; i++) begin
			node_alive[i] = 1'b0;
			node_due[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();

		if (liveness_expected.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				liveness_expected.size());
			error_count++;
		end
		$display("Covered %0d frames and %0d sweeps, %0d results checked", frames_sent,
			ticks_sent, results_checked);
		$display("Nodes joined %0d times and expired %0d times, %0d errors", nodes_joined,
			nodes_expired, error_count);
		if (error_count == 0)
			$display("heartbeat_node_liveness_table_test passed");
		else
			$display("heartbeat_node_liveness_table_test failed");
		$finish;
	end

endmodule
